[rtl/mcdt_pkg.sv]
// shared types and constants for the multi-channel deadline timer
`default_nettype none

package mcdt_pkg;

  // item kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_SERVICE = 2'd2;

  // result kinds
  localparam logic EV_EXPIRY = 1'b0;
  localparam logic EV_REPORT = 1'b1;

  localparam logic [15:0] RESET_MIN_WAIT = 16'd5;

  // one channel entry as stored in the table ram
  typedef struct packed {
    logic [31:0]       deadline;
    logic              action;
    logic signed [4:0] task_id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_CALC,
    ST_REPORT
  } state_t;

endpackage

`default_nettype wire

[rtl/mcdt_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module mcdt_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  we,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                      wdata,
  input  wire                                  re,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/multi_channel_deadline_timer.sv]
// top level of the multi-channel deadline timer with its scan sequencer
// an item runs through ST_CMD, the serial table scan in ST_SCAN, ST_CALC and ST_REPORT
// to the wait report; the result side holding off an expiry event or the report stalls it
// a new item is taken only in ST_IDLE, after the wait report of the last one is loaded
// reset: all channels idle (valid bits cleared at once), min_wait back to 5
// no clearing pass: a channel's valid bit gates the table ram contents
`default_nettype none

module multi_channel_deadline_timer #(
  parameter int CHANNELS = 16
) (
  input  wire                clk,
  input  wire                rst,
  // item input
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [1:0]          kind,
  input  wire [3:0]          timer_id,
  input  wire [31:0]         duration,
  input  wire                has_action,
  input  wire signed [4:0]   task_target,
  input  wire [31:0]         now,
  // result output
  output logic               out_valid,
  input  wire                out_ready,
  output logic               event_kind,
  output logic [3:0]         expired_id,
  output logic signed [4:0]  expired_task,
  output logic               no_timer,
  output logic [31:0]        wait_ticks,
  output logic               last,
  // configuration write
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [15:0]         cfg_data
);

  import mcdt_pkg::*;

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW1 = $clog2(CHANNELS + 1);

  state_t state, state_next;

  // latched item
  logic [1:0]        item_kind;
  logic [3:0]        item_id;
  logic [31:0]       item_duration;
  logic              item_action;
  logic signed [4:0] item_task;
  logic [31:0]       item_now;

  logic [15:0]        min_wait;
  logic [CHANNELS-1:0] valid;

  // scan pipeline
  logic [CW1-1:0] rd_idx;
  logic           ev_vld;
  logic [CW-1:0]  ev_idx;
  logic           found;
  logic [31:0]    earliest;
  logic [31:0]    wait_raw;

  // ram interface
  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  entry_t            ram_wentry;
  logic              ram_re;
  logic [CW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;

  // control
  logic        in_acc;
  logic        out_free;
  logic        id_ok;
  logic [CW-1:0] cmd_idx;
  logic [31:0] start_deadline;
  logic        ev_armed;
  logic        ev_due;
  logic        ev_fire;
  logic        stall;
  logic        scan_done;
  logic        issue;
  logic        load_event;
  logic        load_report;
  logic [31:0] report_wait;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign id_ok          = 32'(item_id) < CHANNELS;
  assign cmd_idx        = CW'(item_id);
  assign start_deadline = item_now + item_duration;

  assign rd_entry  = entry_t'(ram_rdata);
  assign ev_armed  = ev_vld && valid[ev_idx];
  assign ev_due    = ev_armed && (item_kind == KIND_SERVICE) && (rd_entry.deadline <= item_now);
  assign ev_fire   = ev_due && rd_entry.action;
  assign stall     = ev_fire && !out_free;
  assign scan_done = !ev_vld && (rd_idx == CW1'(CHANNELS));
  assign issue     = (state == ST_SCAN) && !stall && (rd_idx != CW1'(CHANNELS));

  // report wait raised to the configured minimum
  assign report_wait = (wait_raw < {16'd0, min_wait}) ? {16'd0, min_wait} : wait_raw;

  mcdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_CMD;
        end
      end
      ST_CMD: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cmd_idx;
    ram_wentry  = '{deadline: start_deadline, action: item_action, task_id: item_task};
    ram_re      = 1'b0;
    ram_raddr   = CW'(rd_idx);
    load_event  = 1'b0;
    load_report = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CMD: begin
        ram_we = (item_kind == KIND_START) && id_ok;
      end
      ST_SCAN: begin
        ram_re     = issue;
        load_event = ev_fire && out_free;
      end
      ST_CALC: begin
      end
      ST_REPORT: begin
        load_report = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_kind     <= kind;
      item_id       <= timer_id;
      item_duration <= duration;
      item_action   <= has_action;
      item_task     <= task_target;
      item_now      <= now;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_wait <= RESET_MIN_WAIT;
    end else if (cfg_valid && cfg_ready) begin
      min_wait <= cfg_data;
    end
  end

  // channel valid bits: set by start (cleared if its deadline sums to zero), cleared by stop and expiry
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if ((state == ST_CMD) && id_ok) begin
        if (item_kind == KIND_START) begin
          valid[cmd_idx] <= (start_deadline != 32'd0);
        end else if (item_kind == KIND_STOP) begin
          valid[cmd_idx] <= 1'b0;
        end
      end
      if ((state == ST_SCAN) && ev_due && !stall) begin
        valid[ev_idx] <= 1'b0;
      end
    end
  end

  // scan pointers: read one channel ahead of the compare
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      ev_vld <= 1'b0;
    end else if (state == ST_CMD) begin
      rd_idx <= '0;
      ev_vld <= 1'b0;
    end else if ((state == ST_SCAN) && !stall) begin
      ev_vld <= issue;
      if (issue) begin
        rd_idx <= rd_idx + CW1'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ev_idx <= CW'(rd_idx);
    end
  end

  // earliest surviving deadline
  always_ff @(posedge clk) begin
    if (state == ST_CMD) begin
      found    <= 1'b0;
      earliest <= '0;
    end else if ((state == ST_SCAN) && ev_armed && !ev_due) begin
      if (!found || (rd_entry.deadline < earliest)) begin
        earliest <= rd_entry.deadline;
      end
      found <= 1'b1;
    end
  end

  // raw wait, zero once the deadline has passed
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      wait_raw <= (earliest <= item_now) ? 32'd0 : (earliest - item_now);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_event || load_report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_event) begin
      event_kind   <= EV_EXPIRY;
      expired_id   <= 4'(ev_idx);
      expired_task <= rd_entry.task_id;
      no_timer     <= 1'b0;
      wait_ticks   <= '0;
      last         <= 1'b0;
    end else if (load_report) begin
      event_kind   <= EV_REPORT;
      expired_id   <= '0;
      expired_task <= '0;
      no_timer     <= !found;
      wait_ticks   <= found ? report_wait : 32'd0;
      last         <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  // busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after accepting an item");

  // only the wait report closes an item
  a_last_is_report: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind == last))
    else $error("last flag does not match result kind");

  // no armed timer gives a zero wait
  a_no_timer_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_timer |-> (wait_ticks == 32'd0) && (event_kind == EV_REPORT))
    else $error("no_timer report with nonzero wait or on an expiry");
`endif

endmodule

`default_nettype wire
